// ===== hw/rtl/text_console_writer_defines.svh =====
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	// Field widths of the command and response ports.
	localparam int OpW   = 2;
	localparam int CharW = 8;
	localparam int ColW  = 7;
	localparam int RowW  = 5;
	localparam int CellW = 16;
	localparam int PosW  = 11;

	// Register port.
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 32;
	localparam logic RegTextAttr = 1'b0;
	localparam logic [CharW-1:0] AttrReset = 8'h07;

	localparam logic [CellW-1:0] BlankCell = 16'h0700;
	localparam logic [CharW-1:0] CharNewline = 8'h0A;
	localparam logic [CharW-1:0] CharBackspace = 8'h08;

	localparam int QueueDepth = 2;

	typedef enum logic [OpW-1:0] {
		OpPut       = 2'd0,
		OpSetCursor = 2'd1,
		OpClear     = 2'd2,
		OpRead      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KindPut,
		KindNewline,
		KindBackspace,
		KindSetCursor,
		KindClear,
		KindRead
	} kind_t;

	// A classified command as it travels from the front end to the back end.
	typedef struct packed {
		kind_t             kind;
		logic [ColW-1:0]   col;
		logic [RowW-1:0]   row;
		logic [CellW-1:0]  word;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcw_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cmd_valid,
	output logic                                 cmd_stall,
	input  wire logic [tcw_pkg::OpW-1:0]         op,
	input  wire logic [tcw_pkg::CharW-1:0]       ch,
	input  wire logic [tcw_pkg::ColW-1:0]        col,
	input  wire logic [tcw_pkg::RowW-1:0]        row,
	input  wire logic [tcw_pkg::CellW-1:0]       fill,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [tcw_pkg::CfgAddrW-1:0]    paddr,
	input  wire logic [tcw_pkg::CfgDataW-1:0]    pwdata,
	output logic      [tcw_pkg::CfgDataW-1:0]    prdata,
	input  wire logic                            queue_full,
	input  wire logic                            init_busy,
	output logic                                 push_valid,
	output tcw_pkg::cmd_t                        push_cmd
);

	logic [tcw_pkg::CharW-1:0] attr_q;
	logic                      attr_sel;

	// Bit 2 of the byte address selects the register; the low bits are ignored.
	assign attr_sel = paddr[tcw_pkg::CfgAddrW-1] == tcw_pkg::RegTextAttr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::AttrReset;
		end else if (psel && penable && pwrite && attr_sel) begin
			attr_q <= pwdata[tcw_pkg::CharW-1:0];
		end
	end

	assign prdata = attr_sel ? tcw_pkg::CfgDataW'(attr_q) : '0;

	assign cmd_stall  = queue_full | init_busy;
	assign push_valid = cmd_valid & ~cmd_stall;

	always_comb begin
		push_cmd.kind = tcw_pkg::KindRead;
		push_cmd.col  = (int'(col) >= COLUMNS) ? tcw_pkg::ColW'(COLUMNS - 1) : col;
		push_cmd.row  = (int'(row) >= ROWS) ? tcw_pkg::RowW'(ROWS - 1) : row;
		push_cmd.word = fill;
		unique case (tcw_pkg::op_t'(op))
			tcw_pkg::OpPut: begin
				push_cmd.word = {attr_q, ch};
				if (ch == tcw_pkg::CharNewline) begin
					push_cmd.kind = tcw_pkg::KindNewline;
				end else if (ch == tcw_pkg::CharBackspace) begin
					push_cmd.kind = tcw_pkg::KindBackspace;
				end else begin
					push_cmd.kind = tcw_pkg::KindPut;
				end
			end
			tcw_pkg::OpSetCursor: push_cmd.kind = tcw_pkg::KindSetCursor;
			tcw_pkg::OpClear:     push_cmd.kind = tcw_pkg::KindClear;
			tcw_pkg::OpRead:      push_cmd.kind = tcw_pkg::KindRead;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	input  wire tcw_pkg::cmd_t  push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                pop_valid,
	output tcw_pkg::cmd_t       pop_cmd
);

	localparam int PtrW = (tcw_pkg::QueueDepth > 1) ? $clog2(tcw_pkg::QueueDepth) : 1;
	localparam int CntW = $clog2(tcw_pkg::QueueDepth + 1);

	tcw_pkg::cmd_t   slot_q [tcw_pkg::QueueDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
		return (p == PtrW'(tcw_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push_valid) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_valid) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push_valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push_valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign full      = count_q == CntW'(tcw_pkg::QueueDepth);
	assign pop_valid = count_q != '0;
	assign pop_cmd   = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        pop_valid,
	input  wire tcw_pkg::cmd_t               pop_cmd,
	output logic                             pop,
	output logic                             init_busy,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output logic [tcw_pkg::PosW-1:0]         cursor_pos,
	output logic                             scrolled,
	output logic [tcw_pkg::CharW-1:0]        cell_char,
	output logic [tcw_pkg::CharW-1:0]        cell_attr
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW = $clog2(CELLS);
	localparam int CW = $clog2(COLUMNS);
	localparam int RW = $clog2(ROWS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RESP  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;

	logic [1:0]                 state_q;
	logic [CW-1:0]              cur_col_q;
	logic [RW-1:0]              cur_row_q;
	logic [RW-1:0]              top_q;
	logic [AW-1:0]              sweep_addr_q;
	logic [AW-1:0]              sweep_last_q;
	logic [tcw_pkg::CellW-1:0]  sweep_word_q;
	logic                       sweep_pend_q;
	logic                       init_q;
	logic                       resp_read_q;
	logic                       resp_scroll_q;
	logic                       rsp_valid_q;
	logic [tcw_pkg::PosW-1:0]   cursor_pos_q;
	logic                       scrolled_q;
	logic [tcw_pkg::CharW-1:0]  cell_char_q;
	logic [tcw_pkg::CharW-1:0]  cell_attr_q;

	logic [CW-1:0]              cmd_col;
	logic [RW-1:0]              cmd_row;
	logic [CW-1:0]              sel_col;
	logic [RW-1:0]              sel_row;
	logic [RW:0]                row_sum;
	logic [RW-1:0]              phys_row;
	logic [AW-1:0]              cell_addr;
	logic [AW-1:0]              top_base;
	logic                       is_read;
	logic                       row_inc;
	logic                       scroll;
	logic [CW-1:0]              col_n;
	logic [RW-1:0]              row_n;
	logic [RW-1:0]              top_n;
	logic                       start_sweep;
	logic [AW-1:0]              sweep_first;
	logic [AW-1:0]              sweep_last;
	logic [tcw_pkg::CellW-1:0]  sweep_word;
	logic                       ram_we;
	logic [AW-1:0]              ram_waddr;
	logic [tcw_pkg::CellW-1:0]  ram_wdata;
	logic                       ram_re;
	logic [tcw_pkg::CellW-1:0]  ram_rdata;
	logic                       slot_free;
	logic                       resp_fire;

	assign pop       = (state_q == ST_IDLE) && pop_valid;
	assign is_read   = pop_cmd.kind == tcw_pkg::KindRead;
	assign cmd_col   = CW'(pop_cmd.col);
	assign cmd_row   = RW'(pop_cmd.row);
	assign sel_col   = is_read ? cmd_col : cur_col_q;
	assign sel_row   = is_read ? cmd_row : cur_row_q;

	// Screen rows live in the RAM as a ring; top_q is the physical row shown first.
	assign row_sum   = (RW + 1)'(top_q) + (RW + 1)'(sel_row);
	assign phys_row  = (row_sum >= (RW + 1)'(ROWS)) ? RW'(row_sum - (RW + 1)'(ROWS))
	                                                : RW'(row_sum);
	assign cell_addr = AW'(phys_row) * AW'(COLUMNS) + AW'(sel_col);
	assign top_base  = AW'(top_q) * AW'(COLUMNS);

	always_comb begin
		col_n       = cur_col_q;
		row_n       = cur_row_q;
		top_n       = top_q;
		row_inc     = 1'b0;
		scroll      = 1'b0;
		start_sweep = 1'b0;
		sweep_first = '0;
		sweep_last  = AW'(CELLS - 1);
		sweep_word  = pop_cmd.word;
		ram_re      = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = cell_addr;
		ram_wdata   = pop_cmd.word;
		if (state_q == ST_SWEEP) begin
			ram_we    = 1'b1;
			ram_waddr = sweep_addr_q;
			ram_wdata = sweep_word_q;
		end
		if (pop) begin
			unique case (pop_cmd.kind)
				tcw_pkg::KindPut: begin
					ram_we = 1'b1;
					if (cur_col_q == CW'(COLUMNS - 1)) begin
						col_n   = '0;
						row_inc = 1'b1;
					end else begin
						col_n = cur_col_q + 1'b1;
					end
				end
				tcw_pkg::KindNewline: begin
					col_n   = '0;
					row_inc = 1'b1;
				end
				tcw_pkg::KindBackspace: begin
					if (cur_col_q != '0) begin
						col_n = cur_col_q - 1'b1;
					end
				end
				tcw_pkg::KindSetCursor: begin
					col_n = cmd_col;
					row_n = cmd_row;
				end
				tcw_pkg::KindClear: begin
					col_n       = '0;
					row_n       = '0;
					start_sweep = 1'b1;
				end
				tcw_pkg::KindRead: ram_re = 1'b1;
				default: ;
			endcase
			if (row_inc) begin
				if (cur_row_q == RW'(ROWS - 1)) begin
					// The old top row becomes the new bottom row and is blanked.
					scroll      = 1'b1;
					col_n       = '0;
					top_n       = (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
					start_sweep = 1'b1;
					sweep_first = top_base;
					sweep_last  = top_base + AW'(COLUMNS - 1);
					sweep_word  = tcw_pkg::BlankCell;
				end else begin
					row_n = cur_row_q + 1'b1;
				end
			end
		end
	end

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign resp_fire = (state_q == ST_RESP) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			cur_col_q     <= '0;
			cur_row_q     <= '0;
			top_q         <= '0;
			sweep_addr_q  <= '0;
			sweep_last_q  <= AW'(CELLS - 1);
			sweep_word_q  <= tcw_pkg::BlankCell;
			sweep_pend_q  <= 1'b0;
			init_q        <= 1'b1;
			resp_read_q   <= 1'b0;
			resp_scroll_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						cur_col_q     <= col_n;
						cur_row_q     <= row_n;
						top_q         <= top_n;
						resp_read_q   <= is_read;
						resp_scroll_q <= scroll;
						sweep_pend_q  <= start_sweep;
						if (start_sweep) begin
							sweep_addr_q <= sweep_first;
							sweep_last_q <= sweep_last;
							sweep_word_q <= sweep_word;
						end
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (slot_free) begin
						state_q <= sweep_pend_q ? ST_SWEEP : ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (sweep_addr_q == sweep_last_q) begin
						state_q <= ST_IDLE;
						init_q  <= 1'b0;
					end else begin
						sweep_addr_q <= sweep_addr_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (resp_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (resp_fire) begin
			cursor_pos_q <= tcw_pkg::PosW'(AW'(cur_row_q) * AW'(COLUMNS) + AW'(cur_col_q));
			scrolled_q   <= resp_scroll_q;
			cell_char_q  <= resp_read_q ? ram_rdata[tcw_pkg::CharW-1:0] : '0;
			cell_attr_q  <= resp_read_q ? ram_rdata[tcw_pkg::CellW-1:tcw_pkg::CharW] : '0;
		end
	end

	tcw_ram #(
		.WIDTH(tcw_pkg::CellW),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(cell_addr),
		.rdata(ram_rdata)
	);

	assign init_busy  = init_q;
	assign rsp_valid  = rsp_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign scrolled   = scrolled_q;
	assign cell_char  = cell_char_q;
	assign cell_attr  = cell_attr_q;

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_writer.sv =====
// Channel   Handshake                      Payload
// cmd       cmd_valid / cmd_stall          op, ch, col, row, fill
// rsp       rsp_valid / rsp_stall          cursor_pos, scrolled, cell_char, cell_attr
// apb       psel, penable, pwrite, pready  paddr, pwdata, prdata (text_attr at 0x0)
//
// Put, newline, backspace, set cursor and read each pass through the back-end sequencer
// in a command state and a response state, which waits while a response is stalled.
// A scroll then blanks one row and a clear fills the screen in a sweep state; both go
// through the screen RAM's single write port, which blanks or fills one cell a cycle.
// After reset the same port fills all COLUMNS*ROWS cells (2000 by default) with 0x0700
// while cmd_stall stays high; register writes are taken throughout.
// The two-entry command queue lets commands be taken while the back end is busy or
// a response is stalled.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_stall,
	input  wire logic [tcw_pkg::OpW-1:0]       op,
	input  wire logic [tcw_pkg::CharW-1:0]     ch,
	input  wire logic [tcw_pkg::ColW-1:0]      col,
	input  wire logic [tcw_pkg::RowW-1:0]      row,
	input  wire logic [tcw_pkg::CellW-1:0]     fill,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic [tcw_pkg::PosW-1:0]           cursor_pos,
	output logic                               scrolled,
	output logic [tcw_pkg::CharW-1:0]          cell_char,
	output logic [tcw_pkg::CharW-1:0]          cell_attr,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [tcw_pkg::CfgAddrW-1:0]  paddr,
	input  wire logic [tcw_pkg::CfgDataW-1:0]  pwdata,
	output logic      [tcw_pkg::CfgDataW-1:0]  prdata,
	output logic                               pready
);

	// Classified commands waiting between the front end and the back end.
	tcw_pkg::cmd_t push_cmd;
	tcw_pkg::cmd_t pop_cmd;
	logic          push_valid;
	logic          queue_full;
	logic          pop_valid;
	logic          pop;
	logic          init_busy;

	// Register accesses complete in their access cycle.
	assign pready = 1'b1;

	// The front end holds the attribute register, saturates coordinates and sorts
	// each put into a printable character, a newline or a backspace.
	tcw_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.op        (op),
		.ch        (ch),
		.col       (col),
		.row       (row),
		.fill      (fill),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.queue_full(queue_full),
		.init_busy (init_busy),
		.push_valid(push_valid),
		.push_cmd  (push_cmd)
	);

	tcw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_cmd  (push_cmd),
		.full      (queue_full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd)
	);

	// The back end owns the cursor, the screen RAM and its row ring, and drives
	// the response register.
	tcw_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.init_busy (init_busy),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cursor_pos(cursor_pos),
		.scrolled  (scrolled),
		.cell_char (cell_char),
		.cell_attr (cell_attr)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "text_console_writer_defines.svh"

module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_stall,
	input wire logic [tcw_pkg::PosW-1:0]   cursor_pos,
	input wire logic                       scrolled,
	input wire logic [tcw_pkg::CharW-1:0]  cell_char,
	input wire logic [tcw_pkg::CharW-1:0]  cell_attr
);

	// After a scroll the cursor sits at the start of the bottom row.
	localparam logic [tcw_pkg::PosW-1:0] ScrollPos = tcw_pkg::PosW'((ROWS - 1) * COLUMNS);

	`TCW_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")
	`TCW_ASSERT_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && rsp_stall, $stable(cursor_pos) && $stable(scrolled) && $stable(cell_char) && $stable(cell_attr), "stalled response changed")
	`TCW_ASSERT_NOW(a_scroll_pos, clk, arst_n, rsp_valid && scrolled, cursor_pos == ScrollPos, "scroll left cursor off the bottom row start")
	`TCW_ASSERT_NOW(a_scroll_no_cell, clk, arst_n, rsp_valid && scrolled, cell_char == '0 && cell_attr == '0, "scrolling response carries cell data")

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.cursor_pos(cursor_pos),
	.scrolled  (scrolled),
	.cell_char (cell_char),
	.cell_attr (cell_attr)
);

`default_nettype wire
